[rtl/nsm_pkg.sv]
// Shared types and constants for the n-shot modifier tracker.
package nsm_pkg;

    // Stream and configuration port widths
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_KEY  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOD_MASK     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALT_MOD_MASK = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOT_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_ROLLS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TERM_MS = 3'd5;

    // Action on the modifier bits
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_REG   = 2'd1,
        ACT_UNREG = 2'd2
    } action_t;

    // Configuration register set
    typedef struct packed {
        logic [15:0] trigger_key;
        logic [7:0]  mod_mask;
        logic [7:0]  alt_mod_mask;
        logic [6:0]  shot_limit;
        logic        count_rolls;
        logic [15:0] hold_term_ms;
    } cfg_t;

    // One key event
    typedef struct packed {
        logic [15:0] key_code;
        logic        key_down;
        logic        use_alt_mask;
        logic        is_cancel;
        logic        is_ignored;
        logic [15:0] now_ms;
    } event_t;

    // One result beat
    typedef struct packed {
        action_t    mod_action;
        logic [7:0] action_mask;
    } result_t;

endpackage

[rtl/nsm_cfg.sv]
// Configuration register file for the n-shot modifier tracker.
module nsm_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nsm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output nsm_pkg::cfg_t                     cfg
);

    nsm_pkg::cfg_t cfg_reg;
    nsm_pkg::cfg_t cfg_next;

    // Writes always complete in one beat
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                nsm_pkg::CFG_TRIGGER_KEY:  cfg_next.trigger_key  = cfg_data;
                nsm_pkg::CFG_MOD_MASK:     cfg_next.mod_mask     = cfg_data[7:0];
                nsm_pkg::CFG_ALT_MOD_MASK: cfg_next.alt_mod_mask = cfg_data[7:0];
                nsm_pkg::CFG_SHOT_LIMIT:   cfg_next.shot_limit   = cfg_data[6:0];
                nsm_pkg::CFG_COUNT_ROLLS:  cfg_next.count_rolls  = cfg_data[0];
                nsm_pkg::CFG_HOLD_TERM_MS: cfg_next.hold_term_ms = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_key  <= 16'd0;
            cfg_reg.mod_mask     <= 8'd0;
            cfg_reg.alt_mod_mask <= 8'd0;
            cfg_reg.shot_limit   <= 7'd1;
            cfg_reg.count_rolls  <= 1'b0;
            cfg_reg.hold_term_ms <= 16'd200;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/nsm_core.sv]
// Modifier entry state and the per-event action decision.
module nsm_core
#(
    parameter int TIME_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  nsm_pkg::event_t    ev,
    input  nsm_pkg::cfg_t      cfg,
    output nsm_pkg::result_t   result
);

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_QUEUED      = 2'd1,
        PH_DOWN_UNUSED = 2'd2,
        PH_DOWN_USED   = 2'd3
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [7:0]            count_reg, count_next;
    logic                  saw_reg, saw_next;
    logic [TIME_BITS-1:0]  press_reg, press_next;

    logic [31:0]           now_wide;
    logic [TIME_BITS-1:0]  now_t;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  held_long;
    logic [7:0]            limit;
    logic [7:0]            count_inc;
    logic [7:0]            rel_count;
    logic [7:0]            mask;
    nsm_pkg::action_t      act;

    // Time in the timer width, elapsed time since the trigger press
    assign now_wide  = 32'(ev.now_ms);
    assign now_t     = now_wide[TIME_BITS-1:0];
    assign elapsed   = now_t - press_reg;
    assign held_long = 32'(elapsed) >= 32'(cfg.hold_term_ms);

    assign limit     = {cfg.shot_limit, 1'b0};
    assign count_inc = count_reg + 8'd1;
    assign rel_count = saw_reg ? count_inc : count_reg;
    assign mask      = ev.use_alt_mask ? cfg.alt_mod_mask : cfg.mod_mask;

    // Next state and action for the event at the head of the input register
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        saw_next   = saw_reg;
        press_next = press_reg;
        act        = nsm_pkg::ACT_NONE;

        if (ev.key_code == cfg.trigger_key)
        begin
            if (ev.key_down)
            begin
                if (phase_reg == PH_IDLE)
                    act = nsm_pkg::ACT_REG;
                phase_next = PH_DOWN_UNUSED;
                count_next = 8'd0;
                saw_next   = cfg.count_rolls;
                press_next = now_t;
            end
            else if (phase_reg == PH_DOWN_UNUSED)
            begin
                if (held_long)
                begin
                    phase_next = PH_IDLE;
                    act        = nsm_pkg::ACT_UNREG;
                end
                else
                begin
                    phase_next = PH_QUEUED;
                end
            end
            else if (phase_reg == PH_DOWN_USED)
            begin
                phase_next = PH_IDLE;
                act        = nsm_pkg::ACT_UNREG;
            end
        end
        else if (ev.key_down)
        begin
            // Other key pressed: cancel, consume a shot, or mark as used
            if (phase_reg != PH_IDLE && ev.is_cancel)
            begin
                phase_next = PH_IDLE;
                count_next = 8'd0;
                saw_next   = cfg.count_rolls;
                act        = nsm_pkg::ACT_UNREG;
            end
            else if (phase_reg == PH_QUEUED && !ev.is_ignored)
            begin
                count_next = count_inc;
                saw_next   = 1'b1;
                if (count_inc == limit)
                begin
                    phase_next = PH_IDLE;
                    count_next = 8'd0;
                    saw_next   = cfg.count_rolls;
                    act        = nsm_pkg::ACT_UNREG;
                end
            end
            else if (phase_reg == PH_DOWN_UNUSED)
            begin
                saw_next = 1'b1;
            end
        end
        else if (!ev.is_ignored)
        begin
            // Other key released
            if (phase_reg == PH_DOWN_UNUSED)
            begin
                if (saw_reg)
                    phase_next = PH_DOWN_USED;
            end
            else if (phase_reg == PH_QUEUED)
            begin
                count_next = rel_count;
                if (rel_count == limit)
                begin
                    phase_next = PH_IDLE;
                    count_next = 8'd0;
                    saw_next   = cfg.count_rolls;
                    act        = nsm_pkg::ACT_UNREG;
                end
            end
        end
    end

    assign result.mod_action  = act;
    assign result.action_mask = (act == nsm_pkg::ACT_NONE) ? 8'd0 : mask;

    // Entry state; press time has no reset since it is written before use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= 8'd0;
            saw_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            saw_reg   <= saw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            press_reg <= press_next;
    end

endmodule

[rtl/nshot_modifier_tracker.sv]
// An accepted key event beat passes through the input register and then the result register.
// Throughput: one event per cycle while m_tready is high; the entry state updates as each
// event moves from the input register to the result register.
// The input register takes a new beat while a result still waits on the output side, if it is empty.
// Reset (rst_n low, asynchronous) empties both registers, clears the entry and loads
// the configuration defaults.
module nshot_modifier_tracker
#(
    parameter int TIME_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Key events
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nsm_pkg::S_TDATA_W-1:0]     s_tdata,  // key_code[15:0], key_down[16], now_ms[32:17], zero[39:33]
    input  logic [nsm_pkg::S_TUSER_W-1:0]     s_tuser,  // use_alt_mask[0], is_cancel[1], is_ignored[2]
    // Actions
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nsm_pkg::M_TDATA_W-1:0]     m_tdata,  // action_mask[7:0]
    output logic [nsm_pkg::M_TUSER_W-1:0]     m_tuser,  // mod_action[1:0]
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    nsm_pkg::cfg_t     cfg;
    nsm_pkg::event_t   ev_reg;
    nsm_pkg::event_t   ev_next;
    logic              in_valid_reg;
    logic              in_valid_next;
    nsm_pkg::result_t  res;
    nsm_pkg::result_t  out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;
    logic              in_beat;

    nsm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nsm_core #(.TIME_BITS(TIME_BITS)) u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ev      (ev_reg),
        .cfg     (cfg),
        .result  (res)
    );

    // Handshake: the held event moves on whenever the result slot is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_beat  = s_tvalid && s_tready;

    // Unpack the incoming beat
    always_comb
    begin
        ev_next.key_code     = s_tdata[15:0];
        ev_next.key_down     = s_tdata[16];
        ev_next.now_ms       = s_tdata[32:17];
        ev_next.use_alt_mask = s_tuser[0];
        ev_next.is_cancel    = s_tuser[1];
        ev_next.is_ignored   = s_tuser[2];
    end

    always_comb
    begin
        in_valid_next = in_beat || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
            ev_reg <= ev_next;
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.action_mask;
    assign m_tuser  = out_reg.mod_action;

endmodule
